/* rtl/rhc_pkg.sv */
package rhc_pkg;

	// channel width used when the top level is not told otherwise
	localparam int CHANNEL_BITS_DEF = 8;
	// width of each colour field on the input stream
	localparam int IN_W = 8;
	// result width, also the number of quotient bits (one per cell)
	localparam int Q_W = 16;

	// pi/3 in Q40, split so that each partial product stays narrow
	localparam logic [40:0] PI3_Q40 = 41'd1151405884119;
	localparam int PI3_LO_W = 21;
	localparam int PI3_HI_W = 20;
	// hue divisor is delta << 27; rounding adds delta << 27 over a divisor of delta << 28
	localparam int HUE_SHIFT = 27;

	localparam logic [Q_W-1:0] GRAY_HUE = 16'd71;
	localparam logic [Q_W-1:0] ONE_Q15 = 16'd32768;
	localparam logic [Q_W-1:0] HUE_MAX = 16'd51471;

endpackage

/* rtl/rgb_to_hls_convert_unit.sv */
// RGB to HLS converter. Takes one pixel per clock and returns lightness and
// saturation in Q1.15 and hue in radians Q3.13, all rounded to nearest; gray
// pixels give saturation 0 and hue 71. The pipeline has three front stages
// (max/min, hue partial products, dividend set-up), a row of 16 divider cells
// that each settle one quotient bit of all three divisions, and the output
// register. Throughput is one item per cycle; each stage holds its item only
// while the next one is full and stalled.
module rgb_to_hls_convert_unit #(
	parameter int CHANNEL_BITS = rhc_pkg::CHANNEL_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // red [7:0], green [15:8], blue [23:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata   // lightness [15:0], saturation [31:16], hue_radians [47:32]
);

	localparam int QW = rhc_pkg::Q_W;
	localparam int LW = CHANNEL_BITS + 17;
	localparam int SW = CHANNEL_BITS + 17;
	localparam int HW = CHANNEL_BITS + 46;

	logic v_c [0:QW];
	logic r_c [0:QW];
	logic [LW-1:0] lr_c [0:QW];
	logic [LW-1:0] ld_c [0:QW];
	logic [SW-1:0] sr_c [0:QW];
	logic [SW-1:0] sd_c [0:QW];
	logic [HW-1:0] hr_c [0:QW];
	logic [HW-1:0] hd_c [0:QW];
	logic [QW-1:0] lq_c [0:QW];
	logic [QW-1:0] sq_c [0:QW];
	logic [QW-1:0] hq_c [0:QW];
	logic g_c [0:QW];

	logic out_valid_q;
	logic [QW-1:0] light_q, sat_q, hue_q;

	rhc_prep #(
		.CHANNEL_BITS(CHANNEL_BITS),
		.LW(LW),
		.SW(SW),
		.HW(HW)
	) u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.red      (s_tdata[7:0]),
		.green    (s_tdata[15:8]),
		.blue     (s_tdata[23:16]),
		.out_valid(v_c[0]),
		.out_ready(r_c[0]),
		.l_rem    (lr_c[0]),
		.l_den    (ld_c[0]),
		.s_rem    (sr_c[0]),
		.s_den    (sd_c[0]),
		.h_rem    (hr_c[0]),
		.h_den    (hd_c[0]),
		.gray     (g_c[0])
	);

	assign lq_c[0] = '0;
	assign sq_c[0] = '0;
	assign hq_c[0] = '0;

	for (genvar i = 0; i < QW; i++) begin : g_cell
		rhc_div_cell #(
			.LW(LW),
			.SW(SW),
			.HW(HW),
			.STEP(QW - 1 - i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (v_c[i]),
			.in_ready (r_c[i]),
			.l_rem_i  (lr_c[i]),
			.l_den_i  (ld_c[i]),
			.l_q_i    (lq_c[i]),
			.s_rem_i  (sr_c[i]),
			.s_den_i  (sd_c[i]),
			.s_q_i    (sq_c[i]),
			.h_rem_i  (hr_c[i]),
			.h_den_i  (hd_c[i]),
			.h_q_i    (hq_c[i]),
			.gray_i   (g_c[i]),
			.out_valid(v_c[i+1]),
			.out_ready(r_c[i+1]),
			.l_rem_o  (lr_c[i+1]),
			.l_den_o  (ld_c[i+1]),
			.l_q_o    (lq_c[i+1]),
			.s_rem_o  (sr_c[i+1]),
			.s_den_o  (sd_c[i+1]),
			.s_q_o    (sq_c[i+1]),
			.h_rem_o  (hr_c[i+1]),
			.h_den_o  (hd_c[i+1]),
			.h_q_o    (hq_c[i+1]),
			.gray_o   (g_c[i+1])
		);
	end

	assign r_c[QW] = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (r_c[QW]) begin
			out_valid_q <= v_c[QW];
		end
	end

	// gray pixels: saturation divisor may be zero, so both fields are forced
	always_ff @(posedge clk) begin
		if (v_c[QW] && r_c[QW]) begin
			light_q <= lq_c[QW];
			sat_q   <= g_c[QW] ? '0 : sq_c[QW];
			hue_q   <= g_c[QW] ? rhc_pkg::GRAY_HUE : hq_c[QW];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {hue_q, sat_q, light_q};

	a_light_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[15:0] <= rhc_pkg::ONE_Q15 && m_tdata[31:16] <= rhc_pkg::ONE_Q15))
		else $error("lightness or saturation above one");

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[47:32] <= rhc_pkg::HUE_MAX))
		else $error("hue beyond full turn");

	a_gray_hue: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[31:16] == '0) |-> (m_tdata[47:32] == rhc_pkg::GRAY_HUE))
		else $error("zero saturation without gray hue marker");

endmodule

/* rtl/rhc_prep.sv */
// Front end: max/min, hue numerator, partial products, then the three
// rounded dividend/divisor pairs handed to the divider cells.
module rhc_prep #(
	parameter int CHANNEL_BITS = rhc_pkg::CHANNEL_BITS_DEF,
	parameter int LW = CHANNEL_BITS + 17,
	parameter int SW = CHANNEL_BITS + 17,
	parameter int HW = CHANNEL_BITS + 46
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [rhc_pkg::IN_W-1:0]       red,
	input  logic [rhc_pkg::IN_W-1:0]       green,
	input  logic [rhc_pkg::IN_W-1:0]       blue,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [LW-1:0]                  l_rem,
	output logic [LW-1:0]                  l_den,
	output logic [SW-1:0]                  s_rem,
	output logic [SW-1:0]                  s_den,
	output logic [HW-1:0]                  h_rem,
	output logic [HW-1:0]                  h_den,
	output logic                           gray
);

	localparam int C = CHANNEL_BITS;
	localparam int EXT = (C > rhc_pkg::IN_W) ? C : rhc_pkg::IN_W;
	localparam int HN_W = C + 3;
	localparam logic [C:0] FULL = (C+1)'((1 << C) - 1);
	localparam logic [rhc_pkg::PI3_LO_W-1:0] P_LO = rhc_pkg::PI3_Q40[rhc_pkg::PI3_LO_W-1:0];
	localparam logic [rhc_pkg::PI3_HI_W-1:0] P_HI =
		rhc_pkg::PI3_Q40[rhc_pkg::PI3_LO_W+rhc_pkg::PI3_HI_W-1:rhc_pkg::PI3_LO_W];

	logic [EXT-1:0] r_ext, g_ext, b_ext;
	logic [C-1:0] r, g, b, hi, lo, delta, sden;
	logic [C:0] sum;
	logic [HN_W-1:0] hn;
	logic [2:0] v_q;
	logic [2:0] rdy;

	// stage 1
	logic [C:0] sum_s1;
	logic [C-1:0] delta_s1, sden_s1;
	logic [HN_W-1:0] hn_s1;
	logic gray_s1;
	// stage 2
	logic [HN_W+rhc_pkg::PI3_HI_W-1:0] php_s2;
	logic [HN_W+rhc_pkg::PI3_LO_W-1:0] plp_s2;
	logic [C-1:0] delta_s2;
	logic [LW-1:0] lrem_s2;
	logic [SW-1:0] srem_s2, sden_s2;
	logic gray_s2;
	// stage 3
	logic [LW-1:0] lrem_s3;
	logic [SW-1:0] srem_s3, sden_s3;
	logic [HW-1:0] hrem_s3, hden_s3;
	logic gray_s3;

	assign r_ext = EXT'(red);
	assign g_ext = EXT'(green);
	assign b_ext = EXT'(blue);
	assign r = r_ext[C-1:0];
	assign g = g_ext[C-1:0];
	assign b = b_ext[C-1:0];

	always_comb begin
		hi = r;
		lo = r;
		if (g > hi) hi = g;
		if (b > hi) hi = b;
		if (g < lo) lo = g;
		if (b < lo) lo = b;
		sum = (C+1)'(hi) + (C+1)'(lo);
		delta = hi - lo;
		sden = (sum <= FULL) ? sum[C-1:0] : C'((FULL << 1) - sum);
		// hue numerator in sextants times delta; stays in [0, 6*delta)
		if (r == hi) begin
			hn = HN_W'(g) - HN_W'(b);
			if (g < b) hn = hn + HN_W'(6) * HN_W'(delta);
		end else if (g == hi) begin
			hn = (HN_W'(delta) << 1) + HN_W'(b) - HN_W'(r);
		end else begin
			hn = (HN_W'(delta) << 2) + HN_W'(r) - HN_W'(g);
		end
	end

	assign rdy[2] = !v_q[2] || out_ready;
	assign rdy[1] = !v_q[1] || rdy[2];
	assign rdy[0] = !v_q[0] || rdy[1];
	assign in_ready = rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (rdy[0]) v_q[0] <= in_valid;
			if (rdy[1]) v_q[1] <= v_q[0];
			if (rdy[2]) v_q[2] <= v_q[1];
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy[0]) begin
			sum_s1   <= sum;
			delta_s1 <= delta;
			sden_s1  <= sden;
			hn_s1    <= hn;
			gray_s1  <= (hi == lo);
		end
		if (v_q[0] && rdy[1]) begin
			php_s2   <= (HN_W+rhc_pkg::PI3_HI_W)'(hn_s1) * (HN_W+rhc_pkg::PI3_HI_W)'(P_HI);
			plp_s2   <= (HN_W+rhc_pkg::PI3_LO_W)'(hn_s1) * (HN_W+rhc_pkg::PI3_LO_W)'(P_LO);
			delta_s2 <= delta_s1;
			lrem_s2  <= (LW'(sum_s1) << 16) + (LW'(FULL) << 1);
			srem_s2  <= (SW'(delta_s1) << 16) + SW'(sden_s1);
			sden_s2  <= SW'(sden_s1) << 1;
			gray_s2  <= gray_s1;
		end
		if (v_q[1] && rdy[2]) begin
			lrem_s3 <= lrem_s2;
			srem_s3 <= srem_s2;
			sden_s3 <= sden_s2;
			hrem_s3 <= (HW'(php_s2) << (rhc_pkg::PI3_LO_W + 1)) + (HW'(plp_s2) << 1)
				+ (HW'(delta_s2) << rhc_pkg::HUE_SHIFT);
			hden_s3 <= HW'(delta_s2) << (rhc_pkg::HUE_SHIFT + 1);
			gray_s3 <= gray_s2;
		end
	end

	assign out_valid = v_q[2];
	assign l_rem = lrem_s3;
	assign l_den = LW'(FULL) << 2;
	assign s_rem = srem_s3;
	assign s_den = sden_s3;
	assign h_rem = hrem_s3;
	assign h_den = hden_s3;
	assign gray  = gray_s3;

endmodule

/* rtl/rhc_div_cell.sv */
// One quotient bit of three restoring divisions, registered, with its own
// valid so that bubbles collapse along the row.
module rhc_div_cell #(
	parameter int LW = 25,
	parameter int SW = 25,
	parameter int HW = 54,
	parameter int STEP = 0
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [LW-1:0]           l_rem_i,
	input  logic [LW-1:0]           l_den_i,
	input  logic [rhc_pkg::Q_W-1:0] l_q_i,
	input  logic [SW-1:0]           s_rem_i,
	input  logic [SW-1:0]           s_den_i,
	input  logic [rhc_pkg::Q_W-1:0] s_q_i,
	input  logic [HW-1:0]           h_rem_i,
	input  logic [HW-1:0]           h_den_i,
	input  logic [rhc_pkg::Q_W-1:0] h_q_i,
	input  logic                    gray_i,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [LW-1:0]           l_rem_o,
	output logic [LW-1:0]           l_den_o,
	output logic [rhc_pkg::Q_W-1:0] l_q_o,
	output logic [SW-1:0]           s_rem_o,
	output logic [SW-1:0]           s_den_o,
	output logic [rhc_pkg::Q_W-1:0] s_q_o,
	output logic [HW-1:0]           h_rem_o,
	output logic [HW-1:0]           h_den_o,
	output logic [rhc_pkg::Q_W-1:0] h_q_o,
	output logic                    gray_o
);

	logic valid_q;
	logic [LW-1:0] l_sh;
	logic [SW-1:0] s_sh;
	logic [HW-1:0] h_sh;
	logic l_ge, s_ge, h_ge;

	assign l_sh = l_den_i << STEP;
	assign s_sh = s_den_i << STEP;
	assign h_sh = h_den_i << STEP;
	assign l_ge = l_rem_i >= l_sh;
	assign s_ge = s_rem_i >= s_sh;
	assign h_ge = h_rem_i >= h_sh;

	assign in_ready = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			l_rem_o <= l_ge ? l_rem_i - l_sh : l_rem_i;
			s_rem_o <= s_ge ? s_rem_i - s_sh : s_rem_i;
			h_rem_o <= h_ge ? h_rem_i - h_sh : h_rem_i;
			l_den_o <= l_den_i;
			s_den_o <= s_den_i;
			h_den_o <= h_den_i;
			l_q_o   <= l_q_i | (rhc_pkg::Q_W'(l_ge) << STEP);
			s_q_o   <= s_q_i | (rhc_pkg::Q_W'(s_ge) << STEP);
			h_q_o   <= h_q_i | (rhc_pkg::Q_W'(h_ge) << STEP);
			gray_o  <= gray_i;
		end
	end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;

	typedef struct packed {
		logic [15:0] lightness;
		logic [15:0] saturation;
		logic [15:0] hue_radians;
	} hls_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // red [7:0], green [15:8], blue [23:16]
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;   // lightness [15:0], saturation [31:16], hue_radians [47:32]

	hls_t pending_hls[$];
	int   error_count;
	bit   hold_off;

	rgb_to_hls_convert_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic logic [63:0] div_round(logic [63:0] num, logic [63:0] den);
		return (2 * num + den) / (2 * den);
	endfunction

	function automatic hls_t convert_pixel(logic [7:0] red, logic [7:0] green,
			logic [7:0] blue);
		logic [63:0] full, r, g, b, hi, lo, sum, delta, sden, hn;
		hls_t res;
		full = 64'd255;
		r = 64'(red); g = 64'(green); b = 64'(blue);
		hi = r; lo = r;
		if (g > hi) hi = g;
		if (b > hi) hi = b;
		if (g < lo) lo = g;
		if (b < lo) lo = b;
		sum = hi + lo;
		res.lightness = 16'(div_round(sum * 32768, 2 * full));
		if (hi == lo) begin
			res.saturation = '0;
			res.hue_radians = rhc_pkg::GRAY_HUE;
			return res;
		end
		delta = hi - lo;
		sden = (sum <= full) ? sum : (2 * full - sum);
		res.saturation = 16'(div_round(delta * 32768, sden));
		if (r == hi) begin
			hn = (g >= b) ? g - b : 6 * delta - (b - g);
		end else if (g == hi) begin
			hn = (b >= r) ? 2 * delta + (b - r) : 2 * delta - (r - b);
		end else begin
			hn = (r >= g) ? 4 * delta + (r - g) : 4 * delta - (g - r);
		end
		res.hue_radians = 16'(div_round(hn * 64'(rhc_pkg::PI3_Q40),
			delta << rhc_pkg::HUE_SHIFT));
		return res;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		error_count++;
	endtask

	function automatic int pick_gap();
		if ($urandom_range(0, 9) < 6) return 0;
		if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// valid stays high after an accepted item; it drops only for a gap or at the end
	task automatic send_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue,
			bit gaps);
		int gap;
		gap = gaps ? pick_gap() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {blue, green, red};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_hls.push_back(convert_pixel(red, green, blue));
	endtask

	// sink: random stalls, plus a long hold-off on request
	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				m_tready <= 1'b0;
			end else begin
				stall = pick_gap();
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		hls_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = hls_t'({m_tdata[15:0], m_tdata[31:16], m_tdata[47:32]});
			if (pending_hls.size() == 0) begin
				report_mismatch("unexpected item", 1, 0);
			end else begin
				want = pending_hls.pop_front();
				if (got.lightness != want.lightness)
					report_mismatch("lightness", int'(got.lightness), int'(want.lightness));
				if (got.saturation != want.saturation)
					report_mismatch("saturation", int'(got.saturation),
						int'(want.saturation));
				if (got.hue_radians != want.hue_radians)
					report_mismatch("hue_radians", int'(got.hue_radians),
						int'(want.hue_radians));
			end
		end
	end

	task automatic test_corner_pixels();
		logic [7:0] corner[6] = '{8'd0, 8'd255, 8'd1, 8'd254, 8'd128, 8'd127};
		// black, white, primaries, secondaries, gray, half lightness
		send_pixel(8'd0, 8'd0, 8'd0, 0);
		send_pixel(8'd255, 8'd255, 8'd255, 0);
		send_pixel(8'd128, 8'd128, 8'd128, 0);
		send_pixel(8'd255, 8'd0, 8'd0, 0);
		send_pixel(8'd0, 8'd255, 8'd0, 0);
		send_pixel(8'd0, 8'd0, 8'd255, 0);
		send_pixel(8'd255, 8'd255, 8'd0, 0);
		send_pixel(8'd0, 8'd255, 8'd255, 1);
		send_pixel(8'd255, 8'd0, 8'd255, 1);
		send_pixel(8'd255, 8'd0, 8'd1, 1);     // red max, hue wraps
		send_pixel(8'd1, 8'd255, 8'd0, 1);     // green max, red above blue
		send_pixel(8'd0, 8'd1, 8'd255, 1);     // blue max, green above red
		send_pixel(8'd200, 8'd55, 8'd100, 1);  // sum exactly full
		send_pixel(8'd200, 8'd56, 8'd100, 1);
		send_pixel(8'd255, 8'd254, 8'd0, 1);
		for (int i = 0; i < 6; i++)
			send_pixel(corner[i], corner[5 - i], corner[(i + 2) % 6], 1);
	endtask

	task automatic test_random_pixels(int count);
		logic [7:0] r, g, b;
		for (int i = 0; i < count; i++) begin
			r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
			case ($urandom_range(0, 3))
				0: g = r;               // ties between channels
				1: b = g;
				default: ;
			endcase
			send_pixel(r, g, b, 1);
		end
	endtask

	task automatic test_backpressure();
		hold_off = 1'b1;
		fork
			begin
				repeat (60) @(posedge clk);
				hold_off = 1'b0;
			end
			for (int i = 0; i < 40; i++)
				send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 0);
		join
	endtask

	initial begin
		int waited;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		hold_off    = 1'b0;
		error_count = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corner_pixels();
		test_backpressure();
		test_random_pixels(360);
		s_tvalid <= 1'b0;
		waited = 0;
		while (pending_hls.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (40) @(posedge clk);
		if (error_count == 0 && pending_hls.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
